// ===== rtl/core/sensor_command_packet_framer_defines.svh =====
// Assertion helpers used by the checker module.
`ifndef SENSOR_COMMAND_PACKET_FRAMER_DEFINES_SVH
`define SENSOR_COMMAND_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpf assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define SCPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpf assertion failed (next cycle)");

`endif

// ===== rtl/core/scpf_pkg.sv =====
package scpf_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int LEN_CAP     = MAX_PAYLOAD + 2;
    localparam int LEN_MIN     = 3;
    localparam int LEN_W       = $clog2(LEN_CAP + 1);

    localparam logic [15:0] START_CODE = 16'hEF01;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0]  IDENT_RESET = 8'h01;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_IDENTIFIER = 1'b1;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        header;
        logic        last;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [7:0]  ident;
        logic [7:0]  len_hi;
        logic [7:0]  len_lo;
        logic [15:0] csum;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [3:0] {
        SEQ_START_HI,
        SEQ_START_LO,
        SEQ_ADDR_3,
        SEQ_ADDR_2,
        SEQ_ADDR_1,
        SEQ_ADDR_0,
        SEQ_IDENT,
        SEQ_LEN_HI,
        SEQ_LEN_LO,
        SEQ_DATA,
        SEQ_SUM_HI,
        SEQ_SUM_LO
    } seq_t;

endpackage

// ===== rtl/core/scpf_front.sv =====
module scpf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  scpf_pkg::fifo_status_t              status,
    input  logic [7:0]                          data_byte,
    input  logic [7:0]                          frame_length,
    input  logic                                cfg_we,
    input  logic [scpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    output logic                                cmd_push,
    output scpf_pkg::cmd_t                      cmd
);
    import scpf_pkg::*;

    logic             frame_open_reg, frame_open_next;
    logic [7:0]       bytes_remaining_reg, bytes_remaining_next;
    logic [15:0]      running_sum_reg, running_sum_next;
    logic [31:0]      device_address_reg, device_address_next;
    logic [7:0]       packet_identifier_reg, packet_identifier_next;

    logic [LEN_W-1:0] len_sat;
    logic [7:0]       len_hi;
    logic [7:0]       len_lo;
    logic [7:0]       rem0;
    logic [7:0]       rem1;
    logic [15:0]      sum0;
    logic [15:0]      sum1;
    logic             is_last;

    assign cmd_push = push && !status.full;

    // Clamp the length field to the legal window
    always_comb
    begin
        len_sat = LEN_W'(frame_length);
        if (len_sat > LEN_W'(LEN_CAP))
        begin
            len_sat = LEN_W'(LEN_CAP);
        end
        if (len_sat < LEN_W'(LEN_MIN))
        begin
            len_sat = LEN_W'(LEN_MIN);
        end
    end

    assign len_hi = 8'(len_sat >> 8);
    assign len_lo = len_sat[7:0];

    always_comb
    begin
        if (frame_open_reg)
        begin
            rem0 = bytes_remaining_reg;
            sum0 = running_sum_reg;
        end
        else
        begin
            rem0 = 8'(len_sat - LEN_W'(2));
            sum0 = 16'(len_hi) + 16'(len_lo) + 16'(packet_identifier_reg);
        end
        rem1    = rem0 - 8'd1;
        sum1    = sum0 + 16'(data_byte);
        is_last = (rem1 == 8'd0);
    end

    always_comb
    begin
        cmd.header = !frame_open_reg;
        cmd.last   = is_last;
        cmd.data   = data_byte;
        cmd.addr   = device_address_reg;
        cmd.ident  = packet_identifier_reg;
        cmd.len_hi = len_hi;
        cmd.len_lo = len_lo;
        cmd.csum   = sum1;
    end

    always_comb
    begin
        frame_open_next      = frame_open_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_sum_next     = running_sum_reg;
        if (cmd_push)
        begin
            if (is_last)
            begin
                frame_open_next      = 1'b0;
                bytes_remaining_next = 8'd0;
                running_sum_next     = 16'd0;
            end
            else
            begin
                frame_open_next      = 1'b1;
                bytes_remaining_next = rem1;
                running_sum_next     = sum1;
            end
        end
    end

    always_comb
    begin
        device_address_next    = device_address_reg;
        packet_identifier_next = packet_identifier_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS:    device_address_next    = cfg_data;
                REG_PACKET_IDENTIFIER: packet_identifier_next = cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg        <= 1'b0;
            bytes_remaining_reg   <= 8'd0;
            running_sum_reg       <= 16'd0;
            device_address_reg    <= ADDR_RESET;
            packet_identifier_reg <= IDENT_RESET;
        end
        else
        begin
            frame_open_reg        <= frame_open_next;
            bytes_remaining_reg   <= bytes_remaining_next;
            running_sum_reg       <= running_sum_next;
            device_address_reg    <= device_address_next;
            packet_identifier_reg <= packet_identifier_next;
        end
    end

endmodule

// ===== rtl/core/scpf_cmd_fifo.sv =====
module scpf_cmd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  scpf_pkg::cmd_t         wr_cmd,
    input  logic                   rd_en,
    output scpf_pkg::cmd_t         rd_cmd,
    output scpf_pkg::fifo_status_t status
);
    import scpf_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign status.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_cmd       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/core/scpf_back.sv =====
module scpf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  scpf_pkg::cmd_t head,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           end_of_frame,
    output logic           last_of_run
);
    import scpf_pkg::*;

    seq_t       step_reg, step_next;
    logic       mid_reg, mid_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       eof_reg;
    logic       lor_reg;

    seq_t       cur_step;
    seq_t       end_step;
    seq_t       succ_step;
    logic       advance;
    logic       done;
    logic [7:0] byte_sel;

    assign cur_step = mid_reg ? step_reg : (head.header ? SEQ_START_HI : SEQ_DATA);
    assign end_step = head.last ? SEQ_SUM_LO : SEQ_DATA;
    assign advance  = (!out_valid_reg || pop) && !cmd_empty;
    assign done     = (cur_step == end_step);
    assign cmd_pop  = advance && done;

    // Next state
    always_comb
    begin
        case (cur_step)
            SEQ_START_HI: succ_step = SEQ_START_LO;
            SEQ_START_LO: succ_step = SEQ_ADDR_3;
            SEQ_ADDR_3:   succ_step = SEQ_ADDR_2;
            SEQ_ADDR_2:   succ_step = SEQ_ADDR_1;
            SEQ_ADDR_1:   succ_step = SEQ_ADDR_0;
            SEQ_ADDR_0:   succ_step = SEQ_IDENT;
            SEQ_IDENT:    succ_step = SEQ_LEN_HI;
            SEQ_LEN_HI:   succ_step = SEQ_LEN_LO;
            SEQ_LEN_LO:   succ_step = SEQ_DATA;
            SEQ_DATA:     succ_step = SEQ_SUM_HI;
            SEQ_SUM_HI:   succ_step = SEQ_SUM_LO;
            default:      succ_step = SEQ_DATA;
        endcase

        step_next = step_reg;
        mid_next  = mid_reg;
        if (advance)
        begin
            if (done)
            begin
                mid_next = 1'b0;
            end
            else
            begin
                mid_next  = 1'b1;
                step_next = succ_step;
            end
        end
    end

    // Outputs: pick the byte for the current step
    always_comb
    begin
        case (cur_step)
            SEQ_START_HI: byte_sel = START_CODE[15:8];
            SEQ_START_LO: byte_sel = START_CODE[7:0];
            SEQ_ADDR_3:   byte_sel = head.addr[31:24];
            SEQ_ADDR_2:   byte_sel = head.addr[23:16];
            SEQ_ADDR_1:   byte_sel = head.addr[15:8];
            SEQ_ADDR_0:   byte_sel = head.addr[7:0];
            SEQ_IDENT:    byte_sel = head.ident;
            SEQ_LEN_HI:   byte_sel = head.len_hi;
            SEQ_LEN_LO:   byte_sel = head.len_lo;
            SEQ_DATA:     byte_sel = head.data;
            SEQ_SUM_HI:   byte_sel = head.csum[15:8];
            SEQ_SUM_LO:   byte_sel = head.csum[7:0];
            default:      byte_sel = head.data;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= SEQ_DATA;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            eof_reg      <= (cur_step == SEQ_SUM_LO);
            lor_reg      <= done;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign end_of_frame = eof_reg;
    assign last_of_run  = lor_reg;

endmodule

// ===== rtl/core/sensor_command_packet_framer.sv =====
// Command packet framer for a fingerprint sensor module's serial link. Push one
// payload byte per transfer; the transfer that opens a frame also carries
// frame_length (payload count plus two, clamped to 3..MAX_PAYLOAD+2). Pop the
// serial stream one byte per transfer: start code EF01, device address (MSB
// first), packet identifier, length high and low, the payload bytes, then the
// 16-bit wrapping checksum of length bytes, identifier and payload, high byte
// first. end_of_frame marks the checksum low byte; last_of_run marks the last
// byte produced by each pushed item. An item yields 1 byte (mid-frame), 3
// (closing), 10 (opening) or 12 (single-byte frame). The output side runs at
// one byte per cycle while pop is held and the queue is not empty, set by
// the byte serializer in the back end; the input side takes an item every
// cycle while the four-entry command queue between the classifier and the
// serializer has room, so full rises only when the consumer or a header
// burst falls behind. An item's first byte goes through the queue, then the
// serializer's output register, when both are empty. device_address and
// packet_identifier are sampled at the frame's first transfer; write them
// with cfg_we/cfg_index/cfg_data while the block is idle.
module sensor_command_packet_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic [7:0]                     frame_length,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     out_byte,
    output logic                           end_of_frame,
    output logic                           last_of_run,
    input  logic                           cfg_we,
    input  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import scpf_pkg::*;

    fifo_status_t q_status;
    cmd_t         front_cmd;
    cmd_t         head_cmd;
    logic         cmd_push;
    logic         cmd_pop;

    // Front: accept, track frame state, build one command per item
    scpf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .status       (q_status),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    // Decouple classification from serialization
    scpf_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_pop),
        .rd_cmd (head_cmd),
        .status (q_status)
    );

    // Back: expand each command into its bytes
    scpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .cmd_empty    (q_status.empty),
        .cmd_pop      (cmd_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run)
    );

    assign full = q_status.full;

endmodule

// ===== rtl/core/scpf_checker.sv =====
`include "sensor_command_packet_framer_defines.svh"

module scpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       end_of_frame,
    input logic       last_of_run
);

    // A waiting byte holds until its transfer
    `SCPF_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_byte))
    // The checksum low byte always closes its item's run
    `SCPF_ASSERT_NOW(a_eof_closes_run, !empty && end_of_frame, last_of_run)
    // Bytes of one item follow without a gap
    `SCPF_ASSERT_NEXT(a_run_contiguous, !empty && pop && !last_of_run, !empty)
    // A full queue implies the serializer has a byte on offer
    `SCPF_ASSERT_NOW(a_full_has_output, full, !empty)

endmodule

bind sensor_command_packet_framer scpf_checker u_scpf_checker (.*);

// ===== bench/sensor_command_packet_framer_checker.sv =====
module sensor_command_packet_framer_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic [7:0]                     frame_length,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [7:0]                     out_byte,
    input  logic                           end_of_frame,
    input  logic                           last_of_run,
    input  logic                           cfg_we,
    input  logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
        logic       lor;
    } serial_byte_t;

    serial_byte_t line_q[$];

    logic [31:0] addr_reg  = scpf_pkg::ADDR_RESET;
    logic [7:0]  ident_reg = scpf_pkg::IDENT_RESET;
    bit          in_frame  = 1'b0;
    logic [7:0]  payload_left = '0;
    logic [15:0] frame_sum = '0;

    task automatic queue_byte(input logic [7:0] value);
        serial_byte_t b;
        b.value = value;
        b.eof   = 1'b0;
        b.lor   = 1'b0;
        line_q.push_back(b);
    endtask

    // Expand one accepted payload byte into the serial bytes it produces.
    task automatic frame_item(input logic [7:0] data, input logic [7:0] len);
        logic [15:0]  flen;
        serial_byte_t tail;
        if (!in_frame) begin
            flen = {8'h00, len};
            if (flen > scpf_pkg::LEN_CAP)
                flen = 16'(scpf_pkg::LEN_CAP);
            if (flen < scpf_pkg::LEN_MIN)
                flen = 16'(scpf_pkg::LEN_MIN);
            queue_byte(scpf_pkg::START_CODE[15:8]);
            queue_byte(scpf_pkg::START_CODE[7:0]);
            queue_byte(addr_reg[31:24]);
            queue_byte(addr_reg[23:16]);
            queue_byte(addr_reg[15:8]);
            queue_byte(addr_reg[7:0]);
            queue_byte(ident_reg);
            queue_byte(flen[15:8]);
            queue_byte(flen[7:0]);
            frame_sum    = 16'(flen[15:8]) + 16'(flen[7:0]) + 16'(ident_reg);
            payload_left = 8'(flen - 16'd2);
            in_frame     = 1'b1;
        end
        queue_byte(data);
        frame_sum    = frame_sum + 16'(data);
        payload_left = payload_left - 8'd1;
        if (payload_left == 8'd0) begin
            queue_byte(frame_sum[15:8]);
            queue_byte(frame_sum[7:0]);
            tail = line_q.pop_back();
            tail.eof = 1'b1;
            line_q.push_back(tail);
            in_frame  = 1'b0;
            frame_sum = '0;
        end
        tail = line_q.pop_back();
        tail.lor = 1'b1;
        line_q.push_back(tail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        serial_byte_t want;
        if (!rst_n) begin
            line_q.delete();
            addr_reg     = scpf_pkg::ADDR_RESET;
            ident_reg    = scpf_pkg::IDENT_RESET;
            in_frame     = 1'b0;
            payload_left = '0;
            frame_sum    = '0;
            mismatches   = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    scpf_pkg::REG_DEVICE_ADDRESS:    addr_reg  = cfg_data;
                    scpf_pkg::REG_PACKET_IDENTIFIER: ident_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (push && !full)
                frame_item(data_byte, frame_length);
            if (pop && !empty) begin
                if (line_q.size() == 0) begin
                    $error("unexpected serial byte: out_byte %0h", out_byte);
                    mismatches++;
                end else begin
                    want = line_q.pop_front();
                    if (out_byte !== want.value) begin
                        $error("out_byte: expected %0h, actual %0h", want.value, out_byte);
                        mismatches++;
                    end
                    if (end_of_frame !== want.eof) begin
                        $error("end_of_frame: expected %0b, actual %0b",
                               want.eof, end_of_frame);
                        mismatches++;
                    end
                    if (last_of_run !== want.lor) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.lor, last_of_run);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = line_q.size();
    end

endmodule

// ===== bench/sensor_command_packet_framer_tb.sv =====
module sensor_command_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scpf_pkg::*;

    // Least count of random payload transfers, not counting the closing and saturated frames at the end.
    localparam int RANDOM_ITEMS = 110;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 push         = 1'b0;
    logic [7:0]           data_byte    = '0;
    logic [7:0]           frame_length = '0;
    logic                 pop          = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_DEVICE_ADDRESS;
    logic [31:0]          cfg_data     = '0;
    logic                 full;
    logic                 empty;
    logic [7:0]           out_byte;
    logic                 end_of_frame;
    logic                 last_of_run;

    int fail_count;
    int pending;
    bit calm = 1'b0;      // set for a stretch with no idling on either side
    int frame_left = 0;   // payload transfers still owed to the open frame

    always #4 clk = ~clk;

    sensor_command_packet_framer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sensor_command_packet_framer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (fail_count),
        .outstanding  (pending)
    );

    // Idle about 38 times in a hundred, except during the calm stretch.
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 38);
    endfunction

    // Payload count that a length field opens, after the block clamps it.
    function automatic int payload_of(input logic [7:0] len);
        int l;
        l = len;
        if (l > LEN_CAP)
            l = LEN_CAP;
        if (l < LEN_MIN)
            l = LEN_MIN;
        return l - 2;
    endfunction

    // Mostly short frames; a few below the minimum and a few long or saturating.
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'($urandom_range(2));
        if (r < 85)
            return 8'($urandom_range(10, 3));
        if (r < 96)
            return 8'($urandom_range(40, 11));
        return 8'($urandom_range(255, 41));
    endfunction

    function automatic logic [31:0] pick_address();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_ident();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Result side: pop at random once reset is released.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= !idle_now();
        end
    end

    // Enter at a falling edge with push not yet driven in this step; leave at
    // the falling edge after the transfer. Scramble the payload lines while idle.
    task automatic send_byte(input logic [7:0] d, input logic [7:0] len);
        while (idle_now())
        begin
            push         <= 1'b0;
            data_byte    <= 8'($urandom_range(255));
            frame_length <= 8'($urandom_range(255));
            @(negedge clk);
        end
        push         <= 1'b1;
        data_byte    <= d;
        frame_length <= len;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Send one payload byte and keep track of where the frame stands.
    task automatic send_item(input logic [7:0] d, input logic [7:0] len);
        if (frame_left == 0)
            frame_left = payload_of(len);
        send_byte(d, len);
        frame_left--;
    endtask

    // Drop push and hold until every expected serial byte has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Write one or both registers on consecutive cycles, then drop the enable.
    // Put random junk above the identifier byte; the block must ignore it.
    task automatic write_config(input bit do_addr, input logic [31:0] addr,
                                input bit do_ident, input logic [7:0] ident);
        if (do_addr)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_DEVICE_ADDRESS;
            cfg_data  <= addr;
            @(negedge clk);
        end
        if (do_ident)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_PACKET_IDENTIFIER;
            cfg_data  <= {24'($urandom), ident};
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int sent;
        int phase;
        int n;
        bit pick;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of address and identifier; lengths below the minimum
        // collapse to a single-byte frame.
        send_item(8'hFF, 8'd0);
        send_item(8'h00, 8'd1);
        send_item(8'h5A, 8'd2);
        send_item(8'hA5, 8'd3);
        send_item(8'h00, 8'd4);
        send_item(8'hFF, 8'd4);
        wait_drained();

        // All-zero header fields.
        write_config(1'b1, 32'h0000_0000, 1'b1, 8'h00);
        send_item(8'h00, 8'd3);
        wait_drained();

        // All-ones header fields and the largest checksum contribution per byte.
        write_config(1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        send_item(8'hFF, 8'd5);
        send_item(8'hFF, 8'hFF);
        send_item(8'hFF, 8'h00);
        wait_drained();

        // Rewrite the registers with a frame open: the open frame keeps the
        // header it already sent, the next frame picks up the new values.
        send_item(8'h12, 8'd6);
        send_item(8'h34, 8'd200);
        wait_drained();
        write_config(1'b1, 32'h1234_5678, 1'b1, 8'h5A);
        send_item(8'h56, 8'd0);
        send_item(8'h78, 8'd255);
        send_item(8'h3C, 8'd3);
        wait_drained();

        // Random phases; each ends drained, possibly mid-frame, and reconfigures.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (phase == 1);
            n = $urandom_range(60, 15);
            for (int i = 0; i < n; i++)
                send_item(8'($urandom_range(255)), pick_length());
            sent += n;
            calm = 1'b0;
            wait_drained();
            pick = $urandom_range(1);
            write_config(pick, pick_address(), !pick || ($urandom_range(1) == 1),
                         pick_ident());
            phase++;
        end

        // Close the open frame, then run one frame at the saturated length.
        while (frame_left != 0)
            send_item(8'($urandom_range(255)), pick_length());
        send_item(8'($urandom_range(255)), 8'd255);
        while (frame_left != 0)
            send_item(8'($urandom_range(255)), pick_length());

        // Drain, then let the block run on idle to show any stray byte.
        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("sensor_command_packet_framer test passed");
        else
            $display("sensor_command_packet_framer test failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #5ms;
        $display("sensor_command_packet_framer test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/scpf_pkg.sv
rtl/core/scpf_front.sv
rtl/core/scpf_cmd_fifo.sv
rtl/core/scpf_back.sv
rtl/core/sensor_command_packet_framer.sv
rtl/core/scpf_checker.sv
bench/sensor_command_packet_framer_checker.sv
bench/sensor_command_packet_framer_tb.sv
